[hw/rtl/hrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types, constants and helpers of the HSL to RGB converter: number
// format, hue ramp segments and the hue point selection function.
// ----------------------------------------------------------------------------
package hrc_pkg;

  // field and number format
  localparam int FIELD_W   = 16;
  localparam int FRAC_BITS = 15;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int THIRD     = ONE / 3;

  // unit range 0..ONE
  localparam int UW = FRAC_BITS + 1;
  // signed working width with headroom over both the fields and the unit range
  localparam int XW = ((FIELD_W > UW) ? FIELD_W : UW) + 3;
  // ramp slope product width
  localparam int PW = (XW - 1) + UW;
  // first product width (lightness times one plus saturation)
  localparam int MW = 2 * UW + 1;

  // segment of the piecewise-linear hue ramp
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HOLD = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } seg_t;

  // ramp segment and slope factor of one hue point
  typedef struct packed {
    seg_t          seg;
    logic [UW-1:0] fac;
  } hue_sel_t;

  // saturate an input field to ONE
  function automatic logic [UW-1:0] clamp_in(input logic [FIELD_W-1:0] v);
    if (XW'(v) > XW'(ONE)) begin
      return UW'(ONE);
    end
    return UW'(v);
  endfunction

  // wrap a hue point once into 0..ONE and pick its ramp segment
  function automatic hue_sel_t hue_sel(input logic signed [XW-1:0] t);
    logic signed [XW-1:0] tw;
    hue_sel_t             r;
    tw = t;
    if (tw < 0) begin
      tw = tw + XW'(ONE);
    end
    if (tw > XW'(ONE)) begin
      tw = tw - XW'(ONE);
    end
    if (tw < 0) begin
      tw = '0;
    end
    if (tw > XW'(ONE)) begin
      tw = XW'(ONE);
    end
    r.seg = SEG_LOW;
    r.fac = '0;
    if (6 * tw < ONE) begin
      r.seg = SEG_RISE;
      r.fac = UW'(6 * tw);
    end else if (2 * tw < ONE) begin
      r.seg = SEG_HOLD;
    end else if (3 * tw < 2 * ONE) begin
      r.seg = SEG_FALL;
      r.fac = UW'(2 * (2 * ONE - 3 * tw));
    end
    return r;
  endfunction

endpackage

[hw/rtl/hsl_to_rgb_converter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit
// Converts one color from hue, saturation and lightness to red, green and
// blue in unsigned Q1.15 (32768 = 1.0), in a five stage pipeline.
// ----------------------------------------------------------------------------
// A color is taken at every clock edge where start is high; busy is always
// low, so one color per clock is sustained. Red, green and blue appear in input
// order with a one cycle done strobe. The receiver cannot hold results off, so
// each result must be captured in the cycle done is high. Inputs above 1.0 are
// saturated to 1.0; outputs stay in 0..1.0. A color passes through the stages
// input clamp, lightness product and hue segment pick, q and p, the three ramp
// products, final sum and clamp.
module hsl_to_rgb_converter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] hue,
  input  logic [15:0] saturation,
  input  logic [15:0] lightness,
  output logic        done,
  output logic [15:0] red,
  output logic [15:0] green,
  output logic [15:0] blue
);

  // stage a: clamped inputs
  logic                       a_valid;
  logic [hrc_pkg::UW-1:0]     a_h;
  logic [hrc_pkg::UW-1:0]     a_s;
  logic [hrc_pkg::UW-1:0]     a_l;

  // stage b: lightness product and hue segments
  logic                       b_valid;
  logic                       b_lo;
  logic [hrc_pkg::MW-1:0]     b_prod;
  logic [hrc_pkg::UW-1:0]     b_s;
  logic [hrc_pkg::UW-1:0]     b_l;
  hrc_pkg::hue_sel_t          b_sel [3];
  logic                       b_lo_next;
  logic [hrc_pkg::UW:0]       b_mul_next;
  logic [hrc_pkg::MW-1:0]     b_prod_next;
  hrc_pkg::hue_sel_t          b_sel_next [3];

  // stage c: q, p and slope
  logic                       c_valid;
  logic signed [hrc_pkg::XW-1:0] c_q;
  logic signed [hrc_pkg::XW-1:0] c_p;
  logic [hrc_pkg::XW-2:0]     c_ud;
  logic                       c_szero;
  logic [hrc_pkg::UW-1:0]     c_l;
  hrc_pkg::hue_sel_t          c_sel [3];
  logic [hrc_pkg::MW-1:0]     c_prod_sh;
  logic signed [hrc_pkg::XW-1:0] c_q_next;
  logic signed [hrc_pkg::XW-1:0] c_p_next;
  logic signed [hrc_pkg::XW-1:0] c_d;
  logic [hrc_pkg::XW-2:0]     c_ud_next;

  // stage d: ramp products
  logic                       d_valid;
  logic [hrc_pkg::PW-1:0]     d_prod [3];
  hrc_pkg::seg_t              d_seg [3];
  logic signed [hrc_pkg::XW-1:0] d_q;
  logic signed [hrc_pkg::XW-1:0] d_p;
  logic                       d_szero;
  logic [hrc_pkg::UW-1:0]     d_l;
  logic [hrc_pkg::PW-1:0]     d_prod_next [3];

  // stage e: final channel values
  logic signed [hrc_pkg::XW-1:0] e_v [3];
  logic [15:0]                e_out [3];

  // the pipeline never stalls
  assign busy = 1'b0;

  // stage a: take a transfer and saturate the inputs
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    a_h <= hrc_pkg::clamp_in(hue);
    a_s <= hrc_pkg::clamp_in(saturation);
    a_l <= hrc_pkg::clamp_in(lightness);
  end

  // stage b: one multiplier for both forms of q, segments of the three hue points
  always_comb begin
    b_lo_next   = (hrc_pkg::XW'(a_l) << 1) < hrc_pkg::XW'(hrc_pkg::ONE);
    b_mul_next  = b_lo_next ? ((hrc_pkg::UW + 1)'(hrc_pkg::ONE) + (hrc_pkg::UW + 1)'(a_s))
                            : (hrc_pkg::UW + 1)'(a_s);
    b_prod_next = hrc_pkg::MW'(a_l) * hrc_pkg::MW'(b_mul_next);
    b_sel_next[0] = hrc_pkg::hue_sel($signed(hrc_pkg::XW'(a_h) + hrc_pkg::XW'(hrc_pkg::THIRD)));
    b_sel_next[1] = hrc_pkg::hue_sel($signed(hrc_pkg::XW'(a_h)));
    b_sel_next[2] = hrc_pkg::hue_sel($signed(hrc_pkg::XW'(a_h) - hrc_pkg::XW'(hrc_pkg::THIRD)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_lo   <= b_lo_next;
    b_prod <= b_prod_next;
    b_s    <= a_s;
    b_l    <= a_l;
    for (int i = 0; i < 3; i++) begin
      b_sel[i] <= b_sel_next[i];
    end
  end

  // stage c: q, p and the non-negative ramp height
  always_comb begin
    c_prod_sh = b_prod >> hrc_pkg::FRAC_BITS;
    if (b_lo) begin
      c_q_next = $signed(hrc_pkg::XW'(c_prod_sh));
    end else begin
      c_q_next = $signed(hrc_pkg::XW'(b_l) + hrc_pkg::XW'(b_s) - hrc_pkg::XW'(c_prod_sh));
    end
    c_p_next  = $signed(hrc_pkg::XW'(b_l) << 1) - c_q_next;
    c_d       = c_q_next - c_p_next;
    c_ud_next = (c_d > 0) ? c_d[hrc_pkg::XW-2:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_q     <= c_q_next;
    c_p     <= c_p_next;
    c_ud    <= c_ud_next;
    c_szero <= (b_s == '0);
    c_l     <= b_l;
    for (int i = 0; i < 3; i++) begin
      c_sel[i] <= b_sel[i];
    end
  end

  // stage d: one slope multiplier per channel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_prod_next[i] = hrc_pkg::PW'(c_ud) * hrc_pkg::PW'(c_sel[i].fac);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
    for (int i = 0; i < 3; i++) begin
      d_prod[i] <= d_prod_next[i];
      d_seg[i]  <= c_sel[i].seg;
    end
    d_q     <= c_q;
    d_p     <= c_p;
    d_szero <= c_szero;
    d_l     <= c_l;
  end

  // stage e: ramp value per segment, gray override, clamp to 0..one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (d_seg[i])
        hrc_pkg::SEG_RISE,
        hrc_pkg::SEG_FALL: e_v[i] = d_p + $signed(hrc_pkg::XW'(d_prod[i] >> hrc_pkg::FRAC_BITS));
        hrc_pkg::SEG_HOLD: e_v[i] = d_q;
        hrc_pkg::SEG_LOW:  e_v[i] = d_p;
        default:           e_v[i] = d_p;
      endcase
      if (d_szero) begin
        e_v[i] = $signed(hrc_pkg::XW'(d_l));
      end
      if (e_v[i] < 0) begin
        e_out[i] = '0;
      end else if (e_v[i] > hrc_pkg::XW'(hrc_pkg::ONE)) begin
        e_out[i] = 16'(hrc_pkg::ONE);
      end else begin
        e_out[i] = 16'(e_v[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
    red   <= e_out[0];
    green <= e_out[1];
    blue  <= e_out[2];
  end

`ifndef ASSERT_OFF
  // a result comes only after a matching transfer
  assert property (@(posedge clk) disable iff (rst) done |-> $past(start && !busy, 5))
    else $error("result without matching transfer");

  // zero saturation gives a gray result
  assert property (@(posedge clk) disable iff (rst)
    done && ($past(saturation, 5) == 16'd0) |-> (red == green) && (green == blue))
    else $error("gray input gave colored result");

  // full lightness gives white
  assert property (@(posedge clk) disable iff (rst)
    done && (32'($past(lightness, 5)) >= hrc_pkg::ONE)
    |-> (32'(red) == hrc_pkg::ONE) && (32'(green) == hrc_pkg::ONE)
        && (32'(blue) == hrc_pkg::ONE))
    else $error("full lightness not white");

  // zero lightness gives black
  assert property (@(posedge clk) disable iff (rst)
    done && ($past(lightness, 5) == 16'd0) |-> (red == 16'd0) && (green == 16'd0)
                                               && (blue == 16'd0))
    else $error("zero lightness not black");

  // channels never exceed one
  assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(red) <= hrc_pkg::ONE) && (32'(green) <= hrc_pkg::ONE)
             && (32'(blue) <= hrc_pkg::ONE))
    else $error("channel above one");
`endif

endmodule
